>>> rtl/lrk4_pkg.sv
package lrk4_pkg;

    localparam int unsigned QW   = 32;    // position / coefficient width
    localparam int unsigned DTW  = 29;    // clamped step size fits here
    localparam int unsigned CIW  = 3;     // config index width
    localparam int unsigned KW   = 42;    // derivative width
    localparam int unsigned SW   = 44;    // weighted derivative sum width
    localparam int unsigned AW   = 48;    // multiplicand width
    localparam int unsigned BW   = 34;    // multiplier width, one bit per cycle
    localparam int unsigned PW   = AW + BW + 1;
    localparam int unsigned DVW  = 44;    // divide-by-six dividend width
    localparam int unsigned EW   = 46;    // pre-saturation width

    localparam logic [DTW-1:0] DT_MAX = 29'd429496729;

    typedef logic signed [QW-1:0] t_q824;
    typedef logic [CIW-1:0]       t_cfg_idx;

    localparam t_cfg_idx CFG_SIGMA   = 3'd0;
    localparam t_cfg_idx CFG_RHO     = 3'd1;
    localparam t_cfg_idx CFG_BETA    = 3'd2;
    localparam t_cfg_idx CFG_START_X = 3'd3;
    localparam t_cfg_idx CFG_START_Y = 3'd4;
    localparam t_cfg_idx CFG_START_Z = 3'd5;

    localparam t_q824 SIGMA_RST = 32'sd167772160;
    localparam t_q824 RHO_RST   = 32'sd469762048;
    localparam t_q824 BETA_RST  = 32'sd44739243;
    localparam t_q824 ONE_Q824  = 32'sd16777216;

    function automatic t_q824 sat32(input logic signed [EW-1:0] v);
        t_q824 r;
        if (v[EW-1:QW-1] == {(EW-QW+1){1'b0}} || v[EW-1:QW-1] == {(EW-QW+1){1'b1}}) begin
            r = v[QW-1:0];
        end else if (v[EW-1]) begin
            r = {1'b1, {(QW-1){1'b0}}};
        end else begin
            r = {1'b0, {(QW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/lrk4_ifs.sv
interface lrk4_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [lrk4_pkg::QW-1:0]      step_size;
    modport source (output valid, action, step_size, input ready);
    modport sink   (input valid, action, step_size, output ready);
endinterface

interface lrk4_out_if;
    logic                         valid;
    logic                         ready;
    lrk4_pkg::t_q824              x_value;
    lrk4_pkg::t_q824              y_value;
    lrk4_pkg::t_q824              z_value;
    modport source (output valid, x_value, y_value, z_value, input ready);
    modport sink   (input valid, x_value, y_value, z_value, output ready);
endinterface

interface lrk4_cfg_if;
    logic                         valid;
    logic                         ready;
    lrk4_pkg::t_cfg_idx           index;
    logic [lrk4_pkg::QW-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lorenz_rk4_integrator_top.sv
// Integrate beat: 28 products of one bit-serial shift-add multiplier, each with a
// load and a writeback, and three divide-by-six passes plus an update each. One
// beat at a time: a new beat is accepted only in idle, and a reload beat returns
// nothing. The result register frees the input side.
// Reset (i_rst_n low, synchronous) restores sigma, rho, beta, start and position.
module lorenz_rk4_integrator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lrk4_in_if.sink      i_in,
    lrk4_out_if.source   o_out,
    lrk4_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_WB, ST_DIV, ST_UPD, ST_DONE} t_state;
    typedef enum logic [2:0] {OP_DX, OP_DY, OP_XY, OP_BZ, OP_AX, OP_AY, OP_AZ} t_op;

    localparam int unsigned CW = 6;
    localparam logic [CW-1:0] MUL_LAST = CW'(lrk4_pkg::BW - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(lrk4_pkg::DVW - 1);
    localparam logic [lrk4_pkg::DVW-1:0] DIV_BIAS = 44'd6 << 41;
    localparam logic signed [lrk4_pkg::EW-1:0] Q_BIAS = 46'sd1 <<< 41;

    t_state r_state;
    t_op    r_op;
    logic [1:0]    r_stage;
    logic [CW-1:0] r_cnt;

    lrk4_pkg::t_q824 r_sigma, r_rho, r_beta, r_sx, r_sy, r_sz;
    lrk4_pkg::t_q824 r_px, r_py, r_pz, r_tx, r_ty, r_tz;
    logic [lrk4_pkg::DTW-1:0] r_dt;
    logic signed [lrk4_pkg::KW-1:0] r_kx, r_ky, r_kz, r_tmp;
    logic signed [lrk4_pkg::SW-1:0] r_sumx, r_sumy, r_sumz;

    logic signed [lrk4_pkg::AW-1:0] r_ma;
    logic [lrk4_pkg::BW-1:0]        r_mb;
    logic signed [lrk4_pkg::AW:0]   r_hi;
    logic [lrk4_pkg::BW-1:0]        r_lo;

    logic [lrk4_pkg::DVW-1:0] r_dq;
    logic [2:0]               r_rem;

    logic r_ovalid;
    lrk4_pkg::t_q824 r_ox, r_oy, r_oz;

    logic signed [lrk4_pkg::AW-1:0] n_ma;
    logic signed [lrk4_pkg::BW-1:0] n_mb;
    logic signed [lrk4_pkg::AW:0]   n_add, n_t;
    logic signed [lrk4_pkg::PW-1:0] n_p;
    logic signed [lrk4_pkg::KW-1:0] n_k24, n_kz;
    logic signed [lrk4_pkg::EW-1:0] n_scl, n_pos, n_upd;
    logic [lrk4_pkg::DVW-1:0]       n_div;
    logic [3:0]                     n_r4;
    logic                           n_ge;
    logic [lrk4_pkg::DTW-1:0]       n_dt;
    lrk4_pkg::t_q824                n_tp;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid   = r_ovalid;
    assign o_out.x_value = r_ox;
    assign o_out.y_value = r_oy;
    assign o_out.z_value = r_oz;

    // dt clamp: at most 0.1, zero becomes one LSB
    always_comb begin
        if (i_in.step_size > {3'b0, lrk4_pkg::DT_MAX}) begin
            n_dt = lrk4_pkg::DT_MAX;
        end else if (i_in.step_size == '0) begin
            n_dt = {{(lrk4_pkg::DTW-1){1'b0}}, 1'b1};
        end else begin
            n_dt = i_in.step_size[lrk4_pkg::DTW-1:0];
        end
    end

    // operand select for the next product
    always_comb begin
        unique case (r_op)
            OP_DX: begin
                n_ma = lrk4_pkg::AW'(r_sigma);
                n_mb = lrk4_pkg::BW'(33'(r_ty) - 33'(r_tx));
            end
            OP_DY: begin
                n_ma = lrk4_pkg::AW'(r_tx);
                n_mb = lrk4_pkg::BW'(33'(r_rho) - 33'(r_tz));
            end
            OP_XY: begin
                n_ma = lrk4_pkg::AW'(r_tx);
                n_mb = lrk4_pkg::BW'(r_ty);
            end
            OP_BZ: begin
                n_ma = lrk4_pkg::AW'(r_beta);
                n_mb = lrk4_pkg::BW'(r_tz);
            end
            OP_AX: begin
                n_ma = (r_stage == 2'd3) ? lrk4_pkg::AW'(r_sumx) : lrk4_pkg::AW'(r_kx);
                n_mb = lrk4_pkg::BW'({1'b0, r_dt});
            end
            OP_AY: begin
                n_ma = (r_stage == 2'd3) ? lrk4_pkg::AW'(r_sumy) : lrk4_pkg::AW'(r_ky);
                n_mb = lrk4_pkg::BW'({1'b0, r_dt});
            end
            OP_AZ: begin
                n_ma = (r_stage == 2'd3) ? lrk4_pkg::AW'(r_sumz) : lrk4_pkg::AW'(r_kz);
                n_mb = lrk4_pkg::BW'({1'b0, r_dt});
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    // one multiplier bit per cycle; the top bit carries negative weight
    always_comb begin
        if (!r_mb[0]) begin
            n_add = '0;
        end else if (r_cnt == MUL_LAST) begin
            n_add = -{r_ma[lrk4_pkg::AW-1], r_ma};
        end else begin
            n_add = {r_ma[lrk4_pkg::AW-1], r_ma};
        end
        n_t = r_hi + n_add;
    end

    always_comb begin
        n_p   = {r_hi, r_lo};
        n_k24 = n_p[24 +: lrk4_pkg::KW];
        n_kz  = r_tmp - n_k24;
        unique case (r_op)
            OP_AX: n_tp = r_px;
            OP_AY: n_tp = r_py;
            default: n_tp = r_pz;
        endcase
        n_pos = lrk4_pkg::EW'(n_tp);
        n_scl = (r_stage == 2'd2) ? n_p[32 +: lrk4_pkg::EW] : n_p[33 +: lrk4_pkg::EW];
        // floor(sum * dt / 2^32) is signed; the bias keeps the dividend positive
        n_div = {{(lrk4_pkg::DVW-lrk4_pkg::KW){n_p[32+lrk4_pkg::KW-1]}},
                 n_p[32 +: lrk4_pkg::KW]} + DIV_BIAS;
        n_upd = n_pos + lrk4_pkg::EW'({1'b0, r_dq}) - Q_BIAS;
        n_r4  = {r_rem, r_dq[lrk4_pkg::DVW-1]};
        n_ge  = (n_r4 >= 4'd6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_DX;
            r_stage  <= 2'd0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_sigma  <= lrk4_pkg::SIGMA_RST;
            r_rho    <= lrk4_pkg::RHO_RST;
            r_beta   <= lrk4_pkg::BETA_RST;
            r_sx     <= lrk4_pkg::ONE_Q824;
            r_sy     <= lrk4_pkg::ONE_Q824;
            r_sz     <= lrk4_pkg::ONE_Q824;
            r_px     <= lrk4_pkg::ONE_Q824;
            r_py     <= lrk4_pkg::ONE_Q824;
            r_pz     <= lrk4_pkg::ONE_Q824;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    lrk4_pkg::CFG_SIGMA:   r_sigma <= i_cfg.data;
                    lrk4_pkg::CFG_RHO:     r_rho   <= i_cfg.data;
                    lrk4_pkg::CFG_BETA:    r_beta  <= i_cfg.data;
                    lrk4_pkg::CFG_START_X: r_sx    <= i_cfg.data;
                    lrk4_pkg::CFG_START_Y: r_sy    <= i_cfg.data;
                    lrk4_pkg::CFG_START_Z: r_sz    <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.action) begin
                            r_px <= r_sx;
                            r_py <= r_sy;
                            r_pz <= r_sz;
                        end else begin
                            r_dt    <= n_dt;
                            r_tx    <= r_px;
                            r_ty    <= r_py;
                            r_tz    <= r_pz;
                            r_op    <= OP_DX;
                            r_stage <= 2'd0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_ma    <= n_ma;
                    r_mb    <= n_mb;
                    r_hi    <= '0;
                    r_lo    <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_hi  <= {n_t[lrk4_pkg::AW], n_t[lrk4_pkg::AW:1]};
                    r_lo  <= {n_t[0], r_lo[lrk4_pkg::BW-1:1]};
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_state <= ST_LOAD;
                    unique case (r_op)
                        OP_DX: begin
                            r_kx <= n_k24;
                            r_op <= OP_DY;
                        end
                        OP_DY: begin
                            r_ky <= n_k24 - lrk4_pkg::KW'(r_ty);
                            r_op <= OP_XY;
                        end
                        OP_XY: begin
                            r_tmp <= n_k24;
                            r_op  <= OP_BZ;
                        end
                        OP_BZ: begin
                            r_kz <= n_kz;
                            r_op <= OP_AX;
                            // RK4 weights 1, 2, 2, 1
                            priority if (r_stage == 2'd0) begin
                                r_sumx <= lrk4_pkg::SW'(r_kx);
                                r_sumy <= lrk4_pkg::SW'(r_ky);
                                r_sumz <= lrk4_pkg::SW'(n_kz);
                            end else if (r_stage == 2'd3) begin
                                r_sumx <= r_sumx + lrk4_pkg::SW'(r_kx);
                                r_sumy <= r_sumy + lrk4_pkg::SW'(r_ky);
                                r_sumz <= r_sumz + lrk4_pkg::SW'(n_kz);
                            end else begin
                                r_sumx <= r_sumx + (lrk4_pkg::SW'(r_kx) <<< 1);
                                r_sumy <= r_sumy + (lrk4_pkg::SW'(r_ky) <<< 1);
                                r_sumz <= r_sumz + (lrk4_pkg::SW'(n_kz) <<< 1);
                            end
                        end
                        default: begin
                            if (r_stage == 2'd3) begin
                                r_dq    <= n_div;
                                r_rem   <= 3'd0;
                                r_cnt   <= '0;
                                r_state <= ST_DIV;
                            end else begin
                                unique case (r_op)
                                    OP_AX: r_tx <= lrk4_pkg::sat32(n_pos + n_scl);
                                    OP_AY: r_ty <= lrk4_pkg::sat32(n_pos + n_scl);
                                    default: r_tz <= lrk4_pkg::sat32(n_pos + n_scl);
                                endcase
                                unique case (r_op)
                                    OP_AX: r_op <= OP_AY;
                                    OP_AY: r_op <= OP_AZ;
                                    default: begin
                                        r_op    <= OP_DX;
                                        r_stage <= r_stage + 2'd1;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                ST_DIV: begin
                    r_rem <= n_ge ? 3'(n_r4 - 4'd6) : n_r4[2:0];
                    r_dq  <= {r_dq[lrk4_pkg::DVW-2:0], n_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    unique case (r_op)
                        OP_AX: begin
                            r_px    <= lrk4_pkg::sat32(n_upd);
                            r_op    <= OP_AY;
                            r_state <= ST_LOAD;
                        end
                        OP_AY: begin
                            r_py    <= lrk4_pkg::sat32(n_upd);
                            r_op    <= OP_AZ;
                            r_state <= ST_LOAD;
                        end
                        default: begin
                            r_pz    <= lrk4_pkg::sat32(n_upd);
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE: begin
                    if (!r_ovalid) begin
                        r_ox     <= r_px;
                        r_oy     <= r_py;
                        r_oz     <= r_pz;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.action)
        |=> (r_state == ST_LOAD && r_op == OP_DX && r_stage == 2'd0))
        else $error("integrate beat did not start the first stage");

    a_mul_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt == MUL_LAST) |=> (r_state == ST_WB))
        else $error("product not written back after last multiplier bit");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < 3'd6))
        else $error("divide-by-six remainder out of range");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_ovalid) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("finished step did not reach the result register");

endmodule
